@@ rtl/core/drls_pkg.sv @@
// Shared types, constants and level tables for the date range level splitter.
`default_nettype none
package drls_pkg;

    localparam int NUM_LEVELS = 12;
    localparam int TAG_SHIFT  = 60;
    localparam int KEY_W      = 60;
    localparam int WORD_W     = 64;
    localparam int POS_W      = 6;
    localparam int LVL_W      = 4;
    localparam int MASK_W     = 12;
    localparam int FW_W       = 4;
    localparam int VAL_W      = 10;

    localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;

    typedef struct packed {
        logic [KEY_W-1:0] range_from;
        logic [KEY_W-1:0] range_to;
    } query_t;

    typedef struct packed {
        logic [WORD_W-1:0] piece_start;
        logic [WORD_W-1:0] piece_end;
        logic              empty_res;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0] piece_start;
        logic [WORD_W-1:0] piece_end;
    } piece_t;

    // One level step as computed by the shared level unit.
    typedef struct packed {
        logic              enabled;
        logic              brk;
        logic              lo_edge;
        logic              hi_edge;
        logic [FW_W-1:0]   w;
        logic [WORD_W-1:0] nlo;
        logic [WORD_W-1:0] nhi;
        piece_t            lo_piece;
        piece_t            hi_piece;
        piece_t            all_piece;
    } lvl_res_t;

    // Control from the sequencer to the output stage.
    typedef struct packed {
        logic   emit;
        logic   finish;
        piece_t piece;
    } out_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_HI,
        ST_DONE
    } seq_state_t;

    function automatic logic [FW_W-1:0] lvl_width(input logic [LVL_W-1:0] lv);
        logic [FW_W-1:0] r;
        case (lv)
            4'd1:    r = 4'd5;
            4'd2:    r = 4'd5;
            4'd3:    r = 4'd3;
            4'd4:    r = 4'd3;
            4'd5:    r = 4'd3;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd2;
            4'd8:    r = 4'd3;
            4'd9:    r = 4'd2;
            4'd10:   r = 4'd3;
            4'd11:   r = 4'd4;
            4'd12:   r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [FW_W-1:0] lvl_wide(input logic [LVL_W-1:0] lv);
        logic [FW_W-1:0] r;
        case (lv)
            4'd1:    r = 4'd10;
            4'd3:    r = 4'd6;
            4'd5:    r = 4'd6;
            4'd7:    r = 4'd5;
            4'd9:    r = 4'd5;
            4'd11:   r = 4'd4;
            4'd12:   r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] lvl_limit(input logic [LVL_W-1:0] lv);
        logic [VAL_W-1:0] r;
        case (lv)
            4'd1:    r = 10'd999;
            4'd2:    r = 10'd31;
            4'd3:    r = 10'd59;
            4'd4:    r = 10'd8;
            4'd5:    r = 10'd59;
            4'd6:    r = 10'd8;
            4'd7:    r = 10'd23;
            4'd8:    r = 10'd5;
            4'd9:    r = 10'd31;
            4'd10:   r = 10'd7;
            4'd11:   r = 10'd12;
            4'd12:   r = 10'd512;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

    function automatic logic has_level(input logic [MASK_W-1:0] mask,
                                       input logic [LVL_W-1:0] lv);
        logic r;
        r = 1'b0;
        if (lv >= 4'd1 && lv <= 4'd12)
        begin
            r = mask[lv - 4'd1];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/drls_level_unit.sv @@
// Shared level unit: edge tests, inward rounding and piece forming for one level.
`default_nettype none
module drls_level_unit import drls_pkg::*; (
    input  wire logic [WORD_W-1:0] lo,
    input  wire logic [WORD_W-1:0] hi,
    input  wire logic [POS_W-1:0]  pos,
    input  wire logic [LVL_W-1:0]  lv,
    input  wire logic [MASK_W-1:0] level_mask,
    output lvl_res_t               res
);

    logic              odd_wide;
    logic [FW_W-1:0]   w;
    logic [FW_W-1:0]   vw;
    logic [VAL_W:0]    vmask_full;
    logic [VAL_W-1:0]  vmask;
    logic [VAL_W-1:0]  rv;
    logic [WORD_W-1:0] fmask;
    logic [WORD_W-1:0] unit;
    logic [WORD_W-1:0] tag;
    logic [WORD_W-1:0] lo_step;
    logic [WORD_W-1:0] hi_step;
    logic [POS_W:0]    upos;
    logic              lo_edge;
    logic              hi_edge;

    always_comb
    begin
        odd_wide = lv[0] && (lv <= 4'd10) && !has_level(level_mask, lv + 4'd1);
        if (odd_wide)
        begin
            w = lvl_width(lv) + lvl_width(lv + 4'd1);
        end
        else if (has_level(level_mask, lv))
        begin
            w = lvl_width(lv);
        end
        else
        begin
            w = '0;
        end

        // Odd levels read the upper value through the wider width.
        vw         = lv[0] ? lvl_wide(lv) : w;
        vmask_full = ((VAL_W+1)'(1) << vw) - (VAL_W+1)'(1);
        vmask      = vmask_full[VAL_W-1:0];
        rv         = VAL_W'(hi >> pos) & vmask;

        fmask   = ((WORD_W'(1) << w) - WORD_W'(1)) << pos;
        lo_edge = (lo & fmask) != '0;
        hi_edge = (rv < lvl_limit(lv)) && ((hi & fmask) != fmask);
        upos    = (POS_W+1)'(pos) + (POS_W+1)'(w);
        unit    = WORD_W'(1) << upos;
        lo_step = lo_edge ? lo + unit : lo;
        hi_step = hi_edge ? hi - unit : hi;
        tag     = WORD_W'(lv) << TAG_SHIFT;

        res.enabled = has_level(level_mask, lv);
        res.lo_edge = lo_edge;
        res.hi_edge = hi_edge;
        res.w       = w;
        res.nlo     = lo_step & ~fmask;
        res.nhi     = hi_step & ~fmask;
        res.brk     = (res.nlo > res.nhi) || (res.nlo < lo) || (res.nhi > hi);

        res.lo_piece.piece_start  = lo | tag;
        res.lo_piece.piece_end    = lo | fmask | tag;
        res.hi_piece.piece_start  = (hi & ~fmask) | tag;
        res.hi_piece.piece_end    = hi | tag;
        res.all_piece.piece_start = lo | tag;
        res.all_piece.piece_end   = hi | tag;
    end

endmodule
`default_nettype wire

@@ rtl/core/drls_seq.sv @@
// Level sequencer: walks the twelve levels through the shared level unit.
`default_nettype none
module drls_seq import drls_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire query_t            query,
    input  wire logic [MASK_W-1:0] level_mask,
    output logic                   busy,
    output out_ctl_t               ctl
);

    seq_state_t        state_reg, state_next;
    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [WORD_W-1:0] hi_reg, hi_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LVL_W-1:0]  lv_reg, lv_next;
    piece_t            hold_reg, hold_next;
    lvl_res_t          lr;

    drls_level_unit u_level (
        .lo         (lo_reg),
        .hi         (hi_reg),
        .pos        (pos_reg),
        .lv         (lv_reg),
        .level_mask (level_mask),
        .res        (lr)
    );

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                if (lr.enabled && lr.brk)
                begin
                    state_next = ST_DONE;
                end
                else if (lr.enabled && lr.lo_edge && lr.hi_edge)
                begin
                    state_next = ST_HI;
                end
                else if (lv_reg == LVL_W'(NUM_LEVELS))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_HI:
            begin
                state_next = (lv_reg > LVL_W'(NUM_LEVELS)) ? ST_DONE : ST_LEVEL;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        lv_next    = lv_reg;
        hold_next  = hold_reg;
        ctl.emit   = 1'b0;
        ctl.finish = 1'b0;
        ctl.piece  = lr.all_piece;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    lo_next  = {{(WORD_W-KEY_W){1'b0}}, query.range_from};
                    hi_next  = {{(WORD_W-KEY_W){1'b0}}, query.range_to};
                    pos_next = '0;
                    lv_next  = LVL_W'(1);
                end
            end
            ST_LEVEL:
            begin
                if (!lr.enabled)
                begin
                    pos_next = pos_reg + POS_W'(lr.w);
                    lv_next  = lv_reg + LVL_W'(1);
                end
                else if (lr.brk)
                begin
                    ctl.emit  = 1'b1;
                    ctl.piece = lr.all_piece;
                end
                else
                begin
                    if (lr.lo_edge)
                    begin
                        ctl.emit  = 1'b1;
                        ctl.piece = lr.lo_piece;
                        hold_next = lr.hi_piece;
                    end
                    else if (lr.hi_edge)
                    begin
                        ctl.emit  = 1'b1;
                        ctl.piece = lr.hi_piece;
                    end
                    lo_next  = lr.nlo;
                    hi_next  = lr.nhi;
                    pos_next = pos_reg + POS_W'(lr.w);
                    lv_next  = lv_reg + LVL_W'(1);
                end
            end
            ST_HI:
            begin
                // Upper edge piece of a level that also had a lower edge.
                ctl.emit  = 1'b1;
                ctl.piece = hold_reg;
            end
            ST_DONE:
            begin
                ctl.finish = 1'b1;
            end
            default:
            begin
                ctl.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        pos_reg  <= pos_next;
        lv_reg   <= lv_next;
        hold_reg <= hold_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/drls_out_stage.sv @@
// Output stage: holds one piece back so the final transfer can carry last.
`default_nettype none
module drls_out_stage import drls_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire out_ctl_t ctl,
    output logic          result_valid,
    output result_t       result
);

    logic    valid_reg, valid_next;
    logic    pend_valid_reg, pend_valid_next;
    piece_t  pend_reg, pend_next;
    result_t result_reg, result_next;

    always_comb
    begin
        valid_next      = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        result_next     = result_reg;
        if (ctl.emit)
        begin
            if (pend_valid_reg)
            begin
                valid_next  = 1'b1;
                result_next = {pend_reg, 1'b0, 1'b0};
            end
            pend_next       = ctl.piece;
            pend_valid_next = 1'b1;
        end
        else if (ctl.finish)
        begin
            valid_next      = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                result_next = {pend_reg, 1'b0, 1'b1};
            end
            else
            begin
                result_next = {{WORD_W{1'b0}}, {WORD_W{1'b0}}, 1'b1, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

@@ rtl/core/date_range_level_split.sv @@
// The sequencer walks the date levels in turn until a break or the last level, with an
// extra ST_HI step for each level that yields two pieces, then a closing ST_DONE step.
// One output register follows; busy drops in the cycle that shows the final piece.
// The shared level unit handles one level per cycle, except while the walk is in ST_HI.
// Each piece is shown for one cycle with result_valid; the receiver cannot stall.
// Reset (rst_n low, asynchronous) returns to idle and sets level_mask to all ones.
`default_nettype none
module date_range_level_split import drls_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire query_t            query,
    output logic                   result_valid,
    output result_t                result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [MASK_W-1:0] cfg_data
);

    logic [MASK_W-1:0] level_mask_reg;
    out_ctl_t          ctl;

    assign cfg_ready = ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_mask_reg <= MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            level_mask_reg <= cfg_data;
        end
    end

    drls_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .query      (query),
        .level_mask (level_mask_reg),
        .busy       (busy),
        .ctl        (ctl)
    );

    drls_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

@@ rtl/core/drls_checker.sv @@
// Port-level checker for the date range level splitter, with its bind.
`default_nettype none
module drls_checker import drls_pkg::*; (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    result_valid,
    input wire result_t result
);

    // A transfer that is not the last of a query only happens while busy.
    a_mid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("non-final piece while not busy");

    // The last transfer frees the block in the same cycle.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("busy still high on final piece");

    // An empty answer is a single, final, all-zero transfer.
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.empty_res |->
            result.last && result.piece_start == '0 && result.piece_end == '0)
        else $error("malformed empty result");

    // An accepted query makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("query accepted without going busy");

endmodule

bind date_range_level_split drls_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for date_range_level_split under several level masks.
`timescale 1ns / 100ps
module tb;
    import drls_pkg::*;

    localparam int unsigned FIELD_BITS [1:12] = '{5, 5, 3, 3, 3, 3, 2, 3, 2, 3, 4, 9};
    localparam int unsigned WIDE_BITS [1:12] = '{10, 0, 6, 0, 6, 0, 5, 0, 5, 0, 4, 9};
    localparam int unsigned FIELD_LIMIT [1:12] =
        '{999, 31, 59, 8, 59, 8, 23, 5, 31, 7, 12, 512};
    localparam int unsigned DATE_CUTS [0:6] = '{10, 16, 22, 27, 32, 36, 45};
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 60;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    query_t            query = '0;
    logic              result_valid;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MASK_W-1:0] cfg_data = '0;

    query_t            query_q[$];
    result_t           pending_pieces[$];
    result_t           due_piece;
    logic [MASK_W-1:0] mask_model = MASK_RESET;
    int                gap_left = 0;
    bit                steady = 1'b0;
    int                errors = 0;
    int                quiet_cycles = 0;

    date_range_level_split dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .query        (query),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void queue_query(input query_t q);
        query_q.insert(query_q.size(), q);
    endfunction

    function automatic bit level_on(input logic [MASK_W-1:0] m, input int lv);
        if (lv < 1 || lv > NUM_LEVELS)
        begin
            return 1'b0;
        end
        return m[lv-1];
    endfunction

    // An odd level whose middle level is off swallows the middle field.
    function automatic int level_span(input logic [MASK_W-1:0] m, input int lv);
        if ((lv % 2) == 1 && lv <= 10 && !level_on(m, lv + 1))
        begin
            return FIELD_BITS[lv] + FIELD_BITS[lv+1];
        end
        if (level_on(m, lv))
        begin
            return FIELD_BITS[lv];
        end
        return 0;
    endfunction

    function automatic result_t piece(input logic [WORD_W-1:0] s, input logic [WORD_W-1:0] e);
        result_t r;
        r = '0;
        r.piece_start = s;
        r.piece_end = e;
        return r;
    endfunction

    // Walks the levels upward and queues the pieces the block must produce for q.
    function automatic void split_query(input query_t q, input logic [MASK_W-1:0] m);
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] vmask;
        logic [WORD_W-1:0] fmask;
        logic [WORD_W-1:0] rv;
        logic [WORD_W-1:0] unit;
        logic [WORD_W-1:0] nlo;
        logic [WORD_W-1:0] nhi;
        logic [WORD_W-1:0] tag;
        int                pos;
        int                w;
        bit                lo_edge;
        bit                hi_edge;
        bit                stop;
        result_t           found[$];
        result_t           r;
        lo = {4'b0, q.range_from};
        hi = {4'b0, q.range_to};
        pos = 0;
        stop = 1'b0;
        for (int lv = 1; lv <= NUM_LEVELS && !stop; lv++)
        begin
            w = level_span(m, lv);
            if (!level_on(m, lv))
            begin
                pos += w;
            end
            else
            begin
                vmask = (64'd1 << w) - 64'd1;
                fmask = vmask << pos;
                if ((lv % 2) == 1)
                begin
                    vmask = (64'd1 << WIDE_BITS[lv]) - 64'd1;
                end
                rv = (hi >> pos) & vmask;
                lo_edge = (lo & fmask) != 64'd0;
                hi_edge = (rv < 64'(FIELD_LIMIT[lv])) && ((hi & fmask) != fmask);
                unit = 64'd1 << (pos + w);
                nlo = (lo_edge ? lo + unit : lo) & ~fmask;
                nhi = (hi_edge ? hi - unit : hi) & ~fmask;
                tag = 64'(lv) << TAG_SHIFT;
                if (nlo > nhi || nlo < lo || nhi > hi)
                begin
                    found.insert(found.size(), piece(lo | tag, hi | tag));
                    stop = 1'b1;
                end
                else
                begin
                    if (lo_edge)
                    begin
                        found.insert(found.size(), piece(lo | tag, lo | fmask | tag));
                    end
                    if (hi_edge)
                    begin
                        found.insert(found.size(), piece((hi & ~fmask) | tag, hi | tag));
                    end
                    lo = nlo;
                    hi = nhi;
                    pos += w;
                end
            end
        end
        if (found.size() == 0)
        begin
            r = '0;
            r.empty_res = 1'b1;
            found.insert(found.size(), r);
        end
        foreach (found[i])
        begin
            r = found[i];
            r.last = (i == found.size() - 1);
            pending_pieces.insert(pending_pieces.size(), r);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] date_key(input int y, input int mo, input int d,
                                                   input int h, input int mi, input int s,
                                                   input int ms);
        return {15'b0, 9'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s), 10'(ms)};
    endfunction

    // Mostly valid calendar fields, now and then a field past its legal range.
    function automatic logic [KEY_W-1:0] rand_date();
        int ms;
        int s;
        int mi;
        int h;
        int d;
        int mo;
        ms = ($urandom_range(0, 19) == 0) ? $urandom_range(1000, 1023) : $urandom_range(0, 999);
        s  = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
        mi = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
        h  = ($urandom_range(0, 19) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
        d  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 31);
        mo = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 15) : $urandom_range(0, 12);
        return date_key($urandom_range(0, 511), mo, d, h, mi, s, ms);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return KEY_W'({$urandom, $urandom});
    endfunction

    function automatic void add_random_query();
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        logic [KEY_W-1:0] keep;
        int               r;
        int               cut;
        r = $urandom_range(0, 99);
        a = rand_date();
        b = rand_date();
        if (r < 55)
        begin
            // Share the upper fields so the walk climbs several levels before it stops.
            cut = DATE_CUTS[$urandom_range(0, 6)];
            keep = (KEY_W'(1) << cut) - KEY_W'(1);
            b = (a & ~keep) | (b & keep);
        end
        else if (r < 85 && r >= 70)
        begin
            b = a + KEY_W'($urandom_range(0, 2000));
        end
        else if (r >= 85)
        begin
            a = rand_key();
            b = ($urandom_range(0, 1) == 0) ? rand_key() : (a | KEY_W'($urandom));
        end
        if (r < 85 && b < a && $urandom_range(0, 9) != 0)
        begin
            queue_query({b, a});
        end
        else
        begin
            queue_query({a, b});
        end
    endfunction

    // Sender: holds start until the block takes the query, then idles for a random gap, or none in a steady phase.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                split_query(query, mask_model);
                gap_left = steady ? 0 : pick_gap();
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (query_q.size() != 0)
                begin
                    query <= query_q.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_pieces.size() == 0)
            begin
                $error("unexpected piece: start %h end %h", result.piece_start,
                       result.piece_end);
                errors++;
            end
            else
            begin
                due_piece = pending_pieces.pop_front();
                check_field("piece_start", due_piece.piece_start, result.piece_start);
                check_field("piece_end", due_piece.piece_end, result.piece_end);
                check_field("empty_res", 64'(due_piece.empty_res), 64'(result.empty_res));
                check_field("last", 64'(due_piece.last), 64'(result.last));
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every query is taken and answered, then let the block settle.
    // The falling edge sees the values that the last rising edge settled.
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (query_q.size() != 0 || start || busy || pending_pieces.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_mask(input logic [MASK_W-1:0] m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mask_model = m;
    endtask

    initial
    begin
        logic [KEY_W-1:0]  d;
        logic [MASK_W-1:0] phase_masks [0:7];
        phase_masks = '{12'hFFF, 12'h555, 12'hAAA, 12'h001, 12'h800,
                        12'(($urandom)), 12'(($urandom)), 12'hFFF};
        d = date_key(300, 6, 15, 12, 30, 30, 500);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed queries under the reset mask.
        queue_query({KEY_W'(0), KEY_W'(0)});
        queue_query({KEY_MAX, KEY_MAX});
        queue_query({KEY_W'(0), KEY_MAX});
        queue_query({KEY_MAX, KEY_W'(0)});
        queue_query({KEY_W'(0), (KEY_W'(1) << 45) - KEY_W'(1)});
        queue_query({d, d});
        queue_query({d, d + KEY_W'(1)});
        queue_query({d + KEY_W'(1), d});
        queue_query({date_key(0, 1, 1, 0, 0, 0, 0), date_key(511, 12, 31, 23, 59, 59, 999)});
        queue_query({date_key(300, 1, 1, 0, 0, 0, 0),
                     date_key(300, 12, 31, 23, 59, 59, 999)});
        queue_query({date_key(300, 6, 15, 0, 0, 0, 0),
                     date_key(300, 6, 15, 23, 59, 59, 999)});
        queue_query({date_key(300, 6, 15, 12, 30, 0, 1),
                     date_key(300, 6, 15, 12, 45, 59, 998)});
        queue_query({date_key(300, 6, 15, 12, 30, 30, 1000),
                     date_key(301, 13, 0, 31, 63, 63, 1023)});
        // Rounding the lower bound up carries out of the 60-bit key.
        queue_query({{15'h7FFF, 45'h1}, KEY_MAX});
        queue_query({date_key(100, 2, 3, 4, 5, 6, 7), date_key(400, 11, 20, 21, 50, 40, 900)});
        drain();

        // With no level indexed every query comes back empty.
        load_mask(12'h000);
        queue_query({KEY_W'(0), KEY_MAX});
        queue_query({d, d + KEY_W'(100)});
        drain();

        // Odd levels only, so each below level eleven takes its middle field as well; then even levels only.
        load_mask(12'h555);
        queue_query({d, d + KEY_W'(1)});
        queue_query({date_key(0, 1, 1, 0, 0, 0, 0), date_key(511, 12, 31, 23, 59, 59, 999)});
        queue_query({date_key(300, 6, 15, 12, 30, 0, 1),
                     date_key(300, 6, 15, 12, 45, 59, 998)});
        drain();
        load_mask(12'hAAA);
        queue_query({d, d + KEY_W'(1)});
        queue_query({date_key(0, 1, 1, 0, 0, 0, 0), date_key(511, 12, 31, 23, 59, 59, 999)});
        queue_query({date_key(300, 6, 15, 12, 30, 0, 1),
                     date_key(300, 6, 15, 12, 45, 59, 998)});
        drain();

        foreach (phase_masks[p])
        begin
            load_mask(phase_masks[p]);
            steady = ($urandom_range(0, 2) == 0);
            repeat (PHASE_ITEMS / 2) add_random_query();
            if ($urandom_range(0, 1) == 0)
            begin
                drain();
            end
            repeat (PHASE_ITEMS / 2) add_random_query();
            drain();
        end

        repeat (30) @(posedge clk);
        if (errors == 0 && pending_pieces.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
